// ===== hdl/assert_macros.svh =====
// assertion macros shared by the deframer modules
// depends on nothing; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define CLDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define CLDF_ASSERT_IMPL(lbl, clk, rst_n, cond, conseq, msg) \
    `CLDF_ASSERT(lbl, clk, rst_n, (cond) |-> (conseq), msg)

`endif

// ===== hdl/cldf_pkg.sv =====
// types, constants and the per-byte header parse function of the deframer
// depends on nothing
package cldf_pkg;

    localparam int LINE_BUFFER_BYTES = 80;
    localparam int MAX_LENGTH_DIGITS = 7;
    localparam int KEY_LEN           = 14;

    localparam int LC_W   = $clog2(LINE_BUFFER_BYTES + 1);
    localparam int DC_W   = $clog2(MAX_LENGTH_DIGITS + 2);
    localparam int KEY_W  = $clog2(KEY_LEN);
    localparam int LEN_W  = 31;
    localparam int PROD_W = LEN_W + 4;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // result kinds
    localparam logic [1:0] KIND_BODY       = 2'd0;
    localparam logic [1:0] KIND_EMPTY      = 2'd1;
    localparam logic [1:0] KIND_BAD_LENGTH = 2'd2;
    localparam logic [1:0] KIND_CLOSED     = 2'd3;

    // special characters
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [1:0] {
        PHASE_HEADER = 2'b01,
        PHASE_BODY   = 2'b10
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       conn_closed;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] body_byte;
        logic       last;
    } result_t;

    // per-line parse flags
    typedef struct packed {
        logic            key_match;
        logic            key_is_len;
        logic            colon_seen;
        logic            skip_spaces;
        logic            zero_seen;
        logic [DC_W-1:0] digit_count;
        logic            value_bad;
    } line_t;

    typedef struct packed {
        line_t            line;
        logic [LEN_W-1:0] msg_len;
    } parse_t;

    localparam line_t LINE_CLEAR = '{
        key_match:   1'b1,
        key_is_len:  1'b0,
        colon_seen:  1'b0,
        skip_spaces: 1'b0,
        zero_seen:   1'b0,
        digit_count: '0,
        value_bad:   1'b0
    };

    // characters of the length key
    function automatic logic [7:0] key_char(input logic [KEY_W-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            KEY_W'(0):  c = 8'h43; // C
            KEY_W'(1):  c = 8'h6F; // o
            KEY_W'(2):  c = 8'h6E; // n
            KEY_W'(3):  c = 8'h74; // t
            KEY_W'(4):  c = 8'h65; // e
            KEY_W'(5):  c = 8'h6E; // n
            KEY_W'(6):  c = 8'h74; // t
            KEY_W'(7):  c = 8'h2D; // -
            KEY_W'(8):  c = 8'h4C; // L
            KEY_W'(9):  c = 8'h65; // e
            KEY_W'(10): c = 8'h6E; // n
            KEY_W'(11): c = 8'h67; // g
            KEY_W'(12): c = 8'h74; // t
            KEY_W'(13): c = 8'h68; // h
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

    // one content byte of a header line at position idx
    function automatic parse_t feed_content(input parse_t s, input logic [7:0] ch,
                                            input logic [LC_W-1:0] idx);
        parse_t            r;
        logic [DC_W-1:0]   cnt;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] ext;
        r    = s;
        ext  = PROD_W'(s.msg_len);
        prod = (ext << 3) + (ext << 1) + PROD_W'(ch[3:0]);
        cnt  = s.line.digit_count;
        if (idx >= LC_W'(LINE_BUFFER_BYTES - 2) || s.line.zero_seen)
        begin
            r = s;
        end
        else if (ch == CHAR_NUL)
        begin
            r.line.zero_seen = 1'b1;
        end
        else if (!s.line.colon_seen)
        begin
            if (ch == CHAR_COLON)
            begin
                r.line.colon_seen  = 1'b1;
                r.line.skip_spaces = 1'b1;
            end
            else if (s.line.key_match && idx < LC_W'(KEY_LEN) &&
                     ch == key_char(idx[KEY_W-1:0]))
            begin
                if (idx == LC_W'(KEY_LEN - 1))
                begin
                    r.line.key_is_len = 1'b1;
                end
            end
            else
            begin
                r.line.key_match  = 1'b0;
                r.line.key_is_len = 1'b0;
            end
        end
        else if (!s.line.key_is_len || (s.line.skip_spaces && ch == CHAR_SPACE))
        begin
            r = s;
        end
        else
        begin
            r.line.skip_spaces = 1'b0;
            if (cnt <= DC_W'(MAX_LENGTH_DIGITS))
            begin
                cnt = cnt + DC_W'(1);
            end
            r.line.digit_count = cnt;
            if (cnt > DC_W'(MAX_LENGTH_DIGITS))
            begin
                r.line.value_bad = 1'b1;
            end
            if (ch < CHAR_ZERO || ch > CHAR_NINE)
            begin
                r.line.value_bad = 1'b1;
            end
            else if (prod > PROD_W'(LEN_MAX))
            begin
                r.msg_len = LEN_MAX;
            end
            else
            begin
                r.msg_len = prod[LEN_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/content_length_header_deframer.sv =====
// top level of the content-length message deframer
// depends on cldf_pkg, cldf_core and cldf_out_buf

// Takes one received byte per transfer and splits the stream into messages
// with CR LF header lines ending at an empty line; a Content-Length header
// sets how many body bytes follow. Each body byte comes out as kind 0 with
// last on the final one; an empty message, a bad length header and a
// connection close come out as status results with last set; the empty message
// and the close start a new message. A byte is taken every cycle while
// item_stall is low: the parse of one byte is a single registered step, and
// its result goes to the output register, or to the skid stage when that is
// held. item_stall rises only when both the output register and its one-entry
// skid stage hold results that the receiver has not taken, so a stalled
// receiver costs at most one extra byte of slack before the input stalls.
module content_length_header_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cldf_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output cldf_pkg::result_t result
);

    logic              accept;
    logic              res_valid;
    cldf_pkg::result_t res;
    logic              full;

    // input transfer
    assign item_stall = full;
    assign accept     = item_valid && !full;

    cldf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    cldf_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (res_valid),
        .push_data    (res),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== hdl/cldf_core.sv =====
// header parser and body counter: one received byte per transfer
// depends on cldf_pkg and assert_macros.svh
`include "assert_macros.svh"

module cldf_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  cldf_pkg::item_t item,
    output logic            res_valid,
    output cldf_pkg::result_t res
);

    cldf_pkg::phase_t                  phase_reg, phase_next;
    logic [cldf_pkg::LC_W-1:0]         line_count_reg, line_count_next;
    logic                              prev_cr_reg, prev_cr_next;
    cldf_pkg::line_t                   line_reg, line_next;
    logic [cldf_pkg::LEN_W-1:0]        msg_len_reg, msg_len_next;
    logic [cldf_pkg::LEN_W-1:0]        body_left_reg, body_left_next;

    logic [cldf_pkg::LC_W-1:0]         idx;
    logic [cldf_pkg::LC_W-1:0]         idx_inc;
    logic                              fin;
    cldf_pkg::parse_t                  p_cur;
    cldf_pkg::parse_t                  p_cr;
    cldf_pkg::parse_t                  p_out;

    assign idx     = line_count_reg;
    assign idx_inc = (idx < cldf_pkg::LC_W'(cldf_pkg::LINE_BUFFER_BYTES)) ?
                     idx + cldf_pkg::LC_W'(1) : idx;
    assign fin     = (body_left_reg <= cldf_pkg::LEN_W'(1));

    // a pending cr becomes content once the next byte is not lf
    always_comb
    begin
        p_cur = '{line: line_reg, msg_len: msg_len_reg};
        p_cr  = prev_cr_reg ?
                cldf_pkg::feed_content(p_cur, cldf_pkg::CHAR_CR, idx - cldf_pkg::LC_W'(1)) :
                p_cur;
        p_out = (item.rx_byte != cldf_pkg::CHAR_CR) ?
                cldf_pkg::feed_content(p_cr, item.rx_byte, idx) : p_cr;
    end

    // next state and result for the accepted byte
    always_comb
    begin
        phase_next      = phase_reg;
        line_count_next = line_count_reg;
        prev_cr_next    = prev_cr_reg;
        line_next       = line_reg;
        msg_len_next    = msg_len_reg;
        body_left_next  = body_left_reg;
        res_valid       = 1'b0;
        res             = '{kind: cldf_pkg::KIND_BODY, body_byte: 8'h00, last: 1'b1};
        if (accept)
        begin
            if (item.conn_closed)
            begin
                phase_next      = cldf_pkg::PHASE_HEADER;
                line_count_next = '0;
                prev_cr_next    = 1'b0;
                line_next       = cldf_pkg::LINE_CLEAR;
                msg_len_next    = '0;
                body_left_next  = '0;
                res_valid       = 1'b1;
                res.kind        = cldf_pkg::KIND_CLOSED;
            end
            else
            begin
                unique case (phase_reg)
                    cldf_pkg::PHASE_BODY:
                    begin
                        res_valid     = 1'b1;
                        res.kind      = cldf_pkg::KIND_BODY;
                        res.body_byte = item.rx_byte;
                        res.last      = fin;
                        if (body_left_reg != '0)
                        begin
                            body_left_next = body_left_reg - cldf_pkg::LEN_W'(1);
                        end
                        if (fin)
                        begin
                            phase_next      = cldf_pkg::PHASE_HEADER;
                            line_count_next = '0;
                            prev_cr_next    = 1'b0;
                            line_next       = cldf_pkg::LINE_CLEAR;
                            msg_len_next    = '0;
                            body_left_next  = '0;
                        end
                    end
                    cldf_pkg::PHASE_HEADER:
                    begin
                        line_count_next = idx_inc;
                        if (prev_cr_reg && item.rx_byte == cldf_pkg::CHAR_LF)
                        begin
                            line_count_next = '0;
                            prev_cr_next    = 1'b0;
                            line_next       = cldf_pkg::LINE_CLEAR;
                            if (idx == cldf_pkg::LC_W'(1))
                            begin
                                // empty line closes the header
                                if (msg_len_reg == '0)
                                begin
                                    res_valid = 1'b1;
                                    res.kind  = cldf_pkg::KIND_EMPTY;
                                end
                                else
                                begin
                                    body_left_next = msg_len_reg;
                                    phase_next     = cldf_pkg::PHASE_BODY;
                                end
                            end
                            else if (line_reg.key_is_len &&
                                     (!line_reg.colon_seen || line_reg.value_bad))
                            begin
                                res_valid    = 1'b1;
                                res.kind     = cldf_pkg::KIND_BAD_LENGTH;
                                msg_len_next = '0;
                            end
                        end
                        else
                        begin
                            prev_cr_next = (item.rx_byte == cldf_pkg::CHAR_CR);
                            line_next    = p_out.line;
                            msg_len_next = p_out.msg_len;
                        end
                    end
                    default:
                    begin
                        phase_next = cldf_pkg::PHASE_HEADER;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= cldf_pkg::PHASE_HEADER;
            line_count_reg <= '0;
            prev_cr_reg    <= 1'b0;
            line_reg       <= cldf_pkg::LINE_CLEAR;
            msg_len_reg    <= '0;
            body_left_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            line_count_reg <= line_count_next;
            prev_cr_reg    <= prev_cr_next;
            line_reg       <= line_next;
            msg_len_reg    <= msg_len_next;
            body_left_reg  <= body_left_next;
        end
    end

    `CLDF_ASSERT_IMPL(a_body_has_bytes, clk, rst_n, phase_reg == cldf_pkg::PHASE_BODY, body_left_reg != '0, "body phase with no bytes left")
    `CLDF_ASSERT_IMPL(a_header_no_body, clk, rst_n, phase_reg == cldf_pkg::PHASE_HEADER, body_left_reg == '0, "body count left over in header")
    `CLDF_ASSERT(a_line_count_cap, clk, rst_n, line_count_reg <= cldf_pkg::LC_W'(cldf_pkg::LINE_BUFFER_BYTES), "line count past its cap")
    `CLDF_ASSERT(a_digit_count_cap, clk, rst_n, line_reg.digit_count <= cldf_pkg::DC_W'(cldf_pkg::MAX_LENGTH_DIGITS + 1), "digit count past its cap")

endmodule

// ===== hdl/cldf_out_buf.sv =====
// result register with a skid stage so the parser keeps taking bytes
// depends on cldf_pkg and assert_macros.svh
`include "assert_macros.svh"

module cldf_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cldf_pkg::result_t push_data,
    output logic              full,
    output logic              result_valid,
    input  logic              result_stall,
    output cldf_pkg::result_t result
);

    logic              out_valid_reg, out_valid_next;
    cldf_pkg::result_t out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    cldf_pkg::result_t skid_data_reg, skid_data_next;
    logic              drain;

    assign drain        = out_valid_reg && !result_stall;
    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // move results: skid first, then a new push
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || drain)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (drain)
        begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `CLDF_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid holds a result ahead of the output")
    `CLDF_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, skid_valid_reg, !push, "push while the skid stage is full")
    `CLDF_ASSERT_IMPL(a_skid_holds, clk, rst_n, skid_valid_reg && result_stall, ##1 skid_valid_reg, "skid result lost during stall")

endmodule
